// File: rtl/mmlp_pkg.sv
// Shared types, character codes, field and status codes of the memory map line parser.
package mmlp_pkg;

    // Field being parsed within the line
    localparam logic [2:0] FLD_ADDR  = 3'd0;
    localparam logic [2:0] FLD_PERM  = 3'd1;
    localparam logic [2:0] FLD_OFFS  = 3'd2;
    localparam logic [2:0] FLD_DEV   = 3'd3;
    localparam logic [2:0] FLD_INODE = 3'd4;
    localparam logic [2:0] FLD_PATH  = 3'd5;

    // Record status codes
    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_NO_SP_ADDR  = 4'd1;
    localparam logic [3:0] ST_NO_HYPHEN   = 4'd2;
    localparam logic [3:0] ST_BAD_START   = 4'd3;
    localparam logic [3:0] ST_BAD_END     = 4'd4;
    localparam logic [3:0] ST_NO_SP_PERM  = 4'd5;
    localparam logic [3:0] ST_NO_SP_OFFS  = 4'd6;
    localparam logic [3:0] ST_BAD_OFFS    = 4'd7;
    localparam logic [3:0] ST_NO_SP_DEV   = 4'd8;
    localparam logic [3:0] ST_NO_SP_INODE = 4'd9;
    localparam logic [3:0] ST_BAD_INODE   = 4'd10;

    // Sharing codes
    localparam logic [1:0] SHR_NONE    = 2'd0;
    localparam logic [1:0] SHR_PRIVATE = 2'd1;
    localparam logic [1:0] SHR_SHARED  = 2'd2;

    // Character codes
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HYPHEN = 8'h2D;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_W      = 8'h77;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_P      = 8'h70;
    localparam logic [7:0] CH_S      = 8'h73;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_digit;

    typedef struct packed {
        logic [63:0] base_addr;
        logic [63:0] limit_addr;
        logic [2:0]  access_bits;
        logic [1:0]  sharing;
        logic [63:0] file_offset;
        logic [7:0]  dev_major;
        logic [7:0]  dev_minor;
        logic [63:0] inode_num;
        logic [11:0] path_start;
        logic [8:0]  path_len;
        logic [3:0]  status;
    } t_rec;

    // Decode one hex digit, either letter case
    function automatic t_digit f_hex_digit(input logic [7:0] c);
        t_digit d;
        d.ok  = 1'b1;
        d.val = c[3:0];
        if (c >= CH_0 && c <= CH_9) begin
            d.val = c[3:0];
        end else if ((c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF)) begin
            d.val = 4'(c[3:0] + 4'd9);
        end else begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage

// File: rtl/mmlp_if.sv
// Valid/ready channels of the memory map line parser: byte requests in, records out.
interface mmlp_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       line_end;

    modport source (output valid, output char_in, output line_end, input ready);
    modport sink   (input valid, input char_in, input line_end, output ready);
endinterface

interface mmlp_rec_if;
    logic        valid;
    logic        ready;
    logic [63:0] base_addr;
    logic [63:0] limit_addr;
    logic [2:0]  access_bits;
    logic [1:0]  sharing;
    logic [63:0] file_offset;
    logic [7:0]  dev_major;
    logic [7:0]  dev_minor;
    logic [63:0] inode_num;
    logic [11:0] path_start;
    logic [8:0]  path_len;
    logic [3:0]  status;

    modport source (output valid, output base_addr, output limit_addr, output access_bits,
                    output sharing, output file_offset, output dev_major, output dev_minor,
                    output inode_num, output path_start, output path_len, output status,
                    input ready);
    modport sink   (input valid, input base_addr, input limit_addr, input access_bits,
                    input sharing, input file_offset, input dev_major, input dev_minor,
                    input inode_num, input path_start, input path_len, input status,
                    output ready);
endinterface

// File: rtl/memory_map_line_parser_unit.sv
// Top level of the memory map line parser: byte request channel in, record channel out.
//
// Usage: one line of a memory-map listing arrives on i_req as one byte per request
// (char_in), with line_end set on the final byte; the newline itself is not sent.
// Each line yields exactly one record on o_rec, carrying the address pair,
// permissions, offset, device numbers, inode, pathname position and length, and a
// status code; fields past the first failure read as zero.
// Throughput: one byte per cycle while i_req.ready is high, across line boundaries.
// The per-byte field state is updated in the cycle the byte is accepted; the hex shift
// and the decimal times-ten add both fit in the parser loop. The finished record is
// registered in the queue head, or in the skid slot while the head is held.
// Reset (synchronous, active low): the parser returns to the start of a line and
// the record queue empties.
// Stall: records wait in a two-entry queue; while the receiver holds ready low the
// parser keeps taking bytes until both entries are full, then i_req.ready drops.
module memory_map_line_parser_unit #(
    parameter int LINE_LIMIT    = 4096,
    parameter int PATH_CAPACITY = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mmlp_req_if.sink   i_req,
    mmlp_rec_if.source o_rec
);

    logic           w_ready;
    logic           w_step;
    logic           w_push;
    mmlp_pkg::t_rec w_new_rec;
    mmlp_pkg::t_rec w_out_rec;

    assign i_req.ready = w_ready;
    assign w_step      = i_req.valid && w_ready;

    // Parse each accepted byte
    mmlp_parser #(
        .LINE_LIMIT    (LINE_LIMIT),
        .PATH_CAPACITY (PATH_CAPACITY)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_char      (i_req.char_in),
        .i_last      (i_req.line_end),
        .o_rec_valid (w_push),
        .o_rec       (w_new_rec)
    );

    // Register and buffer finished records
    mmlp_rec_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_new_rec),
        .o_ready (w_ready),
        .o_valid (o_rec.valid),
        .o_rec   (w_out_rec),
        .i_ready (o_rec.ready)
    );

    assign o_rec.base_addr   = w_out_rec.base_addr;
    assign o_rec.limit_addr  = w_out_rec.limit_addr;
    assign o_rec.access_bits = w_out_rec.access_bits;
    assign o_rec.sharing     = w_out_rec.sharing;
    assign o_rec.file_offset = w_out_rec.file_offset;
    assign o_rec.dev_major   = w_out_rec.dev_major;
    assign o_rec.dev_minor   = w_out_rec.dev_minor;
    assign o_rec.inode_num   = w_out_rec.inode_num;
    assign o_rec.path_start  = w_out_rec.path_start;
    assign o_rec.path_len    = w_out_rec.path_len;
    assign o_rec.status      = w_out_rec.status;

endmodule

// File: rtl/mmlp_parser.sv
// Per-byte field parser: line state registers, next-state logic and record formatting.
module mmlp_parser #(
    parameter int LINE_LIMIT    = 4096,
    parameter int PATH_CAPACITY = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  logic [7:0]    i_char,
    input  logic          i_last,
    output logic          o_rec_valid,
    output mmlp_pkg::t_rec o_rec
);

    localparam int PW = $clog2(LINE_LIMIT);
    localparam logic [PW-1:0] POS_MAX = PW'(LINE_LIMIT - 1);

    typedef struct packed {
        logic [2:0]    field;
        logic [PW-1:0] pos;
        logic [PW-1:0] line_pos;
        logic          hyphen;
        logic [1:0]    bad;
        logic [63:0]   acc_start;
        logic [63:0]   acc_end;
        logic [63:0]   acc_offset;
        logic [63:0]   acc_inode;
        logic [15:0]   dev;
        logic [4:0]    perm;
        logic [3:0]    fail;
        logic          skip_done;
        logic [PW-1:0] path_base;
    } t_pstate;

    t_pstate           r_state;
    t_pstate           n_state;
    t_pstate           w_take;
    mmlp_pkg::t_digit  w_hex;
    logic              w_space;
    logic [63:0]       w_addr_acc;
    logic              w_addr_ok;
    logic              w_offs_ok;
    logic              w_dec_digit;
    logic [67:0]       w_dec_sum;
    logic              w_dec_ovf;
    logic              w_dev_minor;
    logic [3:0]        w_miss;
    logic [3:0]        w_status;
    logic [31:0]       w_plen_full;
    logic [PW+11:0]    w_base_ext;

    function automatic logic [PW-1:0] f_sat(input logic [PW-1:0] v);
        return (v < POS_MAX) ? v + 1'b1 : POS_MAX;
    endfunction

    // Advance to the next space-separated field
    function automatic t_pstate f_next_field(input t_pstate s_in, input logic [PW-1:0] lp);
        t_pstate s;
        s        = s_in;
        s.field  = s_in.field + 3'd1;
        s.pos    = '0;
        s.bad    = '0;
        s.hyphen = 1'b0;
        if (s.field == mmlp_pkg::FLD_PATH) begin
            s.path_base = f_sat(lp);
            s.skip_done = 1'b0;
        end
        return s;
    endfunction

    // Character classification and digit accumulators
    assign w_hex       = mmlp_pkg::f_hex_digit(i_char);
    assign w_space     = (i_char == mmlp_pkg::CH_SPACE);
    assign w_addr_acc  = r_state.hyphen ? r_state.acc_end : r_state.acc_start;
    assign w_addr_ok   = w_hex.ok && (w_addr_acc[63:60] == 4'd0);
    assign w_offs_ok   = w_hex.ok && (r_state.acc_offset[63:60] == 4'd0);
    assign w_dec_digit = (i_char >= mmlp_pkg::CH_0) && (i_char <= mmlp_pkg::CH_9);
    assign w_dec_sum   = {1'b0, r_state.acc_inode, 3'b000} + {3'b000, r_state.acc_inode, 1'b0}
                       + 68'(i_char[3:0]);
    assign w_dec_ovf   = |w_dec_sum[67:64];
    assign w_dev_minor = (r_state.pos >= PW'(3));

    // Apply one character to the line state
    always_comb begin
        t_pstate s;
        s          = r_state;
        s.line_pos = f_sat(r_state.line_pos);
        if (r_state.fail == mmlp_pkg::ST_OK) begin
            unique case (r_state.field)
                mmlp_pkg::FLD_ADDR: begin
                    if (w_space) begin
                        if (!r_state.hyphen) begin
                            s.fail = mmlp_pkg::ST_NO_HYPHEN;
                        end else if (r_state.bad[0]) begin
                            s.fail = mmlp_pkg::ST_BAD_START;
                        end else if (r_state.pos == '0 || r_state.bad[1]) begin
                            s.fail = mmlp_pkg::ST_BAD_END;
                        end else begin
                            s = f_next_field(s, r_state.line_pos);
                        end
                    end else if (!r_state.hyphen && i_char == mmlp_pkg::CH_HYPHEN) begin
                        if (r_state.pos == '0) begin
                            s.bad[0] = 1'b1;
                        end
                        s.hyphen = 1'b1;
                        s.pos    = '0;
                    end else begin
                        if (w_addr_ok) begin
                            if (r_state.hyphen) begin
                                s.acc_end = {w_addr_acc[59:0], w_hex.val};
                            end else begin
                                s.acc_start = {w_addr_acc[59:0], w_hex.val};
                            end
                        end else if (r_state.hyphen) begin
                            s.bad[1] = 1'b1;
                        end else begin
                            s.bad[0] = 1'b1;
                        end
                        s.pos = f_sat(r_state.pos);
                    end
                end
                mmlp_pkg::FLD_PERM: begin
                    if (w_space) begin
                        s = f_next_field(s, r_state.line_pos);
                    end else begin
                        if (r_state.pos == PW'(0) && i_char == mmlp_pkg::CH_R) begin
                            s.perm[0] = 1'b1;
                        end
                        if (r_state.pos == PW'(1) && i_char == mmlp_pkg::CH_W) begin
                            s.perm[1] = 1'b1;
                        end
                        if (r_state.pos == PW'(2) && i_char == mmlp_pkg::CH_X) begin
                            s.perm[2] = 1'b1;
                        end
                        if (r_state.pos == PW'(3) && i_char == mmlp_pkg::CH_P) begin
                            s.perm[3] = 1'b1;
                        end else if (r_state.pos == PW'(3) && i_char == mmlp_pkg::CH_S) begin
                            s.perm[4] = 1'b1;
                        end
                        s.pos = f_sat(r_state.pos);
                    end
                end
                mmlp_pkg::FLD_OFFS: begin
                    if (w_space) begin
                        if (r_state.pos == '0 || r_state.bad != 2'b00) begin
                            s.fail = mmlp_pkg::ST_BAD_OFFS;
                        end else begin
                            s = f_next_field(s, r_state.line_pos);
                        end
                    end else begin
                        if (w_offs_ok) begin
                            s.acc_offset = {r_state.acc_offset[59:0], w_hex.val};
                        end else begin
                            s.bad[0] = 1'b1;
                        end
                        s.pos = f_sat(r_state.pos);
                    end
                end
                mmlp_pkg::FLD_DEV: begin
                    if (w_space) begin
                        // drop a part that is missing or holds a bad digit
                        s.dev[7:0]  = (r_state.pos >= PW'(1) && !r_state.bad[0])
                                    ? r_state.dev[7:0] : 8'h00;
                        s.dev[15:8] = (r_state.pos >= PW'(4) && !r_state.bad[1])
                                    ? r_state.dev[15:8] : 8'h00;
                        s = f_next_field(s, r_state.line_pos);
                    end else begin
                        if (r_state.pos <= PW'(1) || r_state.pos == PW'(3)
                                || r_state.pos == PW'(4)) begin
                            if (!w_hex.ok) begin
                                if (w_dev_minor) begin
                                    s.bad[1] = 1'b1;
                                end else begin
                                    s.bad[0] = 1'b1;
                                end
                            end else if (w_dev_minor) begin
                                s.dev[15:8] = {r_state.dev[11:8], w_hex.val};
                            end else begin
                                s.dev[7:0] = {r_state.dev[3:0], w_hex.val};
                            end
                        end
                        s.pos = f_sat(r_state.pos);
                    end
                end
                mmlp_pkg::FLD_INODE: begin
                    if (w_space) begin
                        if (r_state.pos == '0 || r_state.bad != 2'b00) begin
                            s.fail = mmlp_pkg::ST_BAD_INODE;
                        end else begin
                            s = f_next_field(s, r_state.line_pos);
                        end
                    end else begin
                        if (w_dec_digit && !w_dec_ovf) begin
                            s.acc_inode = w_dec_sum[63:0];
                        end else begin
                            s.bad[0] = 1'b1;
                        end
                        s.pos = f_sat(r_state.pos);
                    end
                end
                default: begin
                    // pathname: mark the first non-space, then count
                    if (!r_state.skip_done && !w_space) begin
                        s.skip_done = 1'b1;
                        s.path_base = r_state.line_pos;
                        s.pos       = PW'(1);
                    end else begin
                        s.pos = f_sat(r_state.pos);
                    end
                end
            endcase
        end
        w_take = s;
    end

    // Clear the line state after the last byte
    assign n_state = i_last ? '0 : w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_step) begin
            r_state <= n_state;
        end
    end

    // Map a line that ends inside a field to its missing-space status
    always_comb begin
        case (w_take.field)
            mmlp_pkg::FLD_ADDR:  w_miss = mmlp_pkg::ST_NO_SP_ADDR;
            mmlp_pkg::FLD_PERM:  w_miss = mmlp_pkg::ST_NO_SP_PERM;
            mmlp_pkg::FLD_OFFS:  w_miss = mmlp_pkg::ST_NO_SP_OFFS;
            mmlp_pkg::FLD_DEV:   w_miss = mmlp_pkg::ST_NO_SP_DEV;
            mmlp_pkg::FLD_INODE: w_miss = mmlp_pkg::ST_NO_SP_INODE;
            default:             w_miss = mmlp_pkg::ST_OK;
        endcase
    end

    assign w_status    = (w_take.fail != mmlp_pkg::ST_OK) ? w_take.fail : w_miss;
    assign w_plen_full = (32'(w_take.pos) < 32'(PATH_CAPACITY))
                       ? 32'(w_take.pos) : 32'(PATH_CAPACITY);
    assign w_base_ext  = {12'b0, w_take.path_base};

    // Format the record, zeroing fields past the failure point
    always_comb begin
        logic ok;
        ok = (w_status == mmlp_pkg::ST_OK);
        o_rec.base_addr   = (ok || w_status >= mmlp_pkg::ST_BAD_END)
                          ? w_take.acc_start : '0;
        o_rec.limit_addr  = (ok || w_status >= mmlp_pkg::ST_NO_SP_PERM)
                          ? w_take.acc_end : '0;
        o_rec.access_bits = (ok || w_status >= mmlp_pkg::ST_NO_SP_OFFS)
                          ? w_take.perm[2:0] : 3'b000;
        if (!(ok || w_status >= mmlp_pkg::ST_NO_SP_OFFS)) begin
            o_rec.sharing = mmlp_pkg::SHR_NONE;
        end else if (w_take.perm[3]) begin
            o_rec.sharing = mmlp_pkg::SHR_PRIVATE;
        end else if (w_take.perm[4]) begin
            o_rec.sharing = mmlp_pkg::SHR_SHARED;
        end else begin
            o_rec.sharing = mmlp_pkg::SHR_NONE;
        end
        o_rec.file_offset = (ok || w_status >= mmlp_pkg::ST_NO_SP_DEV)
                          ? w_take.acc_offset : '0;
        o_rec.dev_major   = (ok || w_status >= mmlp_pkg::ST_NO_SP_INODE)
                          ? w_take.dev[7:0] : 8'h00;
        o_rec.dev_minor   = (ok || w_status >= mmlp_pkg::ST_NO_SP_INODE)
                          ? w_take.dev[15:8] : 8'h00;
        o_rec.inode_num   = ok ? w_take.acc_inode : '0;
        o_rec.path_start  = ok ? w_base_ext[11:0] : 12'h000;
        o_rec.path_len    = ok ? w_plen_full[8:0] : 9'h000;
        o_rec.status      = w_status;
    end

    assign o_rec_valid = i_step && i_last;

`ifndef SYNTHESIS
    a_hyphen_in_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.hyphen |-> (r_state.field == mmlp_pkg::FLD_ADDR))
        else $error("hyphen flag set outside the address field");

    a_skip_in_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.skip_done |-> (r_state.field == mmlp_pkg::FLD_PATH))
        else $error("pathname start marked outside the pathname field");

    a_fail_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.fail != mmlp_pkg::ST_OK && !(i_step && i_last))
        |=> ($stable(r_state.field) && $stable(r_state.fail)))
        else $error("parsing advanced after a failure");
`endif

endmodule

// File: rtl/mmlp_rec_queue.sv
// Two-entry record queue: output register plus skid slot between parser and receiver.
module mmlp_rec_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mmlp_pkg::t_rec i_rec,
    output logic           o_ready,
    output logic           o_valid,
    output mmlp_pkg::t_rec o_rec,
    input  logic           i_ready
);

    mmlp_pkg::t_rec r_head;
    mmlp_pkg::t_rec r_tail;
    mmlp_pkg::t_rec n_head;
    mmlp_pkg::t_rec n_tail;
    logic           r_head_vld;
    logic           r_tail_vld;
    logic           n_head_vld;
    logic           n_tail_vld;
    logic           w_pop;

    assign w_pop = r_head_vld && i_ready;

    // Refill the head from the skid slot or the incoming record
    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_head_vld = r_head_vld;
        n_tail_vld = r_tail_vld;
        if (w_pop || !r_head_vld) begin
            if (r_tail_vld) begin
                n_head     = r_tail;
                n_head_vld = 1'b1;
                n_tail     = i_rec;
                n_tail_vld = i_push;
            end else begin
                n_head     = i_rec;
                n_head_vld = i_push;
                n_tail_vld = 1'b0;
            end
        end else if (i_push) begin
            n_tail     = i_rec;
            n_tail_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_vld <= 1'b0;
            r_tail_vld <= 1'b0;
        end else begin
            r_head_vld <= n_head_vld;
            r_tail_vld <= n_tail_vld;
        end
    end

    // Hold payload without reset
    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_tail <= n_tail;
    end

    assign o_ready = !r_tail_vld;
    assign o_valid = r_head_vld;
    assign o_rec   = r_head;

`ifndef SYNTHESIS
    a_tail_behind_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail_vld |-> r_head_vld)
        else $error("skid slot occupied while head is empty");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !r_tail_vld)
        else $error("record pushed into a full queue");
`endif

endmodule

// File: sim/mmlp_record_checker.sv
// Record checker of the memory map line parser: predicts records from requests, compares.
module mmlp_record_checker #(
    parameter int LINE_LIMIT    = 4096,
    parameter int PATH_CAPACITY = 256
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mmlp_req_if  i_req,
    mmlp_rec_if  i_rec,
    output int   o_mismatches,
    output int   o_outstanding
);

    // Shadow parser state for the line in flight
    logic [2:0]  fld;
    int unsigned fpos;
    int unsigned lpos;
    int unsigned pbase;
    logic        hyph;
    logic        skip_done;
    logic [1:0]  bad;
    logic [63:0] acc_start;
    logic [63:0] acc_end;
    logic [63:0] acc_offs;
    logic [63:0] acc_inode;
    logic [15:0] acc_dev;
    logic [4:0]  perm;
    logic [3:0]  fail;

    mmlp_pkg::t_rec expected_recs[$];
    mmlp_pkg::t_rec oldest;
    int             fails = 0;

    function automatic int unsigned bump(input int unsigned v);
        return (v < LINE_LIMIT - 1) ? v + 1 : LINE_LIMIT - 1;
    endfunction

    // Value of a hex character, -1 when it is not one
    function automatic int hex_value(input logic [7:0] c);
        if (c >= mmlp_pkg::CH_0 && c <= mmlp_pkg::CH_9)
            return int'(c) - int'(mmlp_pkg::CH_0);
        if (c >= mmlp_pkg::CH_LA && c <= mmlp_pkg::CH_LF)
            return int'(c) - int'(mmlp_pkg::CH_LA) + 10;
        if (c >= mmlp_pkg::CH_UA && c <= mmlp_pkg::CH_UF)
            return int'(c) - int'(mmlp_pkg::CH_UA) + 10;
        return -1;
    endfunction

    // Shift one hex digit in; refuse non-digits and anything that would overflow
    task automatic shift_hex(inout logic [63:0] acc, input logic [7:0] c, output logic ok);
        int d;
        d = hex_value(c);
        ok = 1'b0;
        if (d >= 0 && acc[63:60] == 4'd0) begin
            acc = {acc[59:0], 4'(d)};
            ok  = 1'b1;
        end
    endtask

    task automatic clear_line();
        fld       = mmlp_pkg::FLD_ADDR;
        fpos      = 0;
        lpos      = 0;
        pbase     = 0;
        hyph      = 1'b0;
        skip_done = 1'b0;
        bad       = 2'b00;
        acc_start = '0;
        acc_end   = '0;
        acc_offs  = '0;
        acc_inode = '0;
        acc_dev   = '0;
        perm      = '0;
        fail      = mmlp_pkg::ST_OK;
    endtask

    task automatic next_field();
        fld  = fld + 3'd1;
        fpos = 0;
        bad  = 2'b00;
        hyph = 1'b0;
        if (fld == mmlp_pkg::FLD_PATH) begin
            pbase     = bump(lpos);
            skip_done = 1'b0;
        end
    endtask

    // Advance the shadow parser by one character
    task automatic parse_char(input logic [7:0] c);
        logic        ok;
        int          d;
        logic        minor;
        logic [7:0]  maj;
        logic [7:0]  mnr;
        logic [63:0] digit;
        case (fld)
            mmlp_pkg::FLD_ADDR: begin
                if (c == mmlp_pkg::CH_SPACE) begin
                    if (!hyph) fail = mmlp_pkg::ST_NO_HYPHEN;
                    else if (bad[0]) fail = mmlp_pkg::ST_BAD_START;
                    else if (fpos == 0 || bad[1]) fail = mmlp_pkg::ST_BAD_END;
                    else next_field();
                end else if (!hyph && c == mmlp_pkg::CH_HYPHEN) begin
                    if (fpos == 0) bad[0] = 1'b1;
                    hyph = 1'b1;
                    fpos = 0;
                end else begin
                    if (hyph) shift_hex(acc_end, c, ok);
                    else shift_hex(acc_start, c, ok);
                    if (!ok) begin
                        if (hyph) bad[1] = 1'b1;
                        else bad[0] = 1'b1;
                    end
                    fpos = bump(fpos);
                end
            end
            mmlp_pkg::FLD_PERM: begin
                if (c == mmlp_pkg::CH_SPACE) begin
                    next_field();
                end else begin
                    if (fpos == 0 && c == mmlp_pkg::CH_R) perm[0] = 1'b1;
                    if (fpos == 1 && c == mmlp_pkg::CH_W) perm[1] = 1'b1;
                    if (fpos == 2 && c == mmlp_pkg::CH_X) perm[2] = 1'b1;
                    if (fpos == 3 && c == mmlp_pkg::CH_P) perm[3] = 1'b1;
                    else if (fpos == 3 && c == mmlp_pkg::CH_S) perm[4] = 1'b1;
                    fpos = bump(fpos);
                end
            end
            mmlp_pkg::FLD_OFFS: begin
                if (c == mmlp_pkg::CH_SPACE) begin
                    if (fpos == 0 || bad != 2'b00) fail = mmlp_pkg::ST_BAD_OFFS;
                    else next_field();
                end else begin
                    shift_hex(acc_offs, c, ok);
                    if (!ok) bad[0] = 1'b1;
                    fpos = bump(fpos);
                end
            end
            mmlp_pkg::FLD_DEV: begin
                if (c == mmlp_pkg::CH_SPACE) begin
                    // drop a part that is missing or holds a bad digit
                    maj = (fpos >= 1 && !bad[0]) ? acc_dev[7:0] : 8'd0;
                    mnr = (fpos >= 4 && !bad[1]) ? acc_dev[15:8] : 8'd0;
                    acc_dev = {mnr, maj};
                    next_field();
                end else begin
                    if (fpos <= 1 || fpos == 3 || fpos == 4) begin
                        d     = hex_value(c);
                        minor = (fpos >= 3);
                        if (d < 0) begin
                            if (minor) bad[1] = 1'b1;
                            else bad[0] = 1'b1;
                        end else if (minor) begin
                            acc_dev[15:8] = {acc_dev[11:8], 4'(d)};
                        end else begin
                            acc_dev[7:0] = {acc_dev[3:0], 4'(d)};
                        end
                    end
                    fpos = bump(fpos);
                end
            end
            mmlp_pkg::FLD_INODE: begin
                if (c == mmlp_pkg::CH_SPACE) begin
                    if (fpos == 0 || bad != 2'b00) fail = mmlp_pkg::ST_BAD_INODE;
                    else next_field();
                end else begin
                    if (c >= mmlp_pkg::CH_0 && c <= mmlp_pkg::CH_9) begin
                        digit = 64'(c - mmlp_pkg::CH_0);
                        if (acc_inode > (64'hFFFF_FFFF_FFFF_FFFF - digit) / 64'd10)
                            bad[0] = 1'b1;
                        else
                            acc_inode = acc_inode * 64'd10 + digit;
                    end else begin
                        bad[0] = 1'b1;
                    end
                    fpos = bump(fpos);
                end
            end
            default: begin
                // pathname: hold the start until the first non-space
                if (!skip_done && c != mmlp_pkg::CH_SPACE) begin
                    skip_done = 1'b1;
                    pbase     = lpos;
                    fpos      = 1;
                end else begin
                    fpos = bump(fpos);
                end
            end
        endcase
    endtask

    // Form the record of a finished line and queue it
    task automatic close_line();
        mmlp_pkg::t_rec r;
        logic [3:0]     st;
        int unsigned    plen;
        st = fail;
        if (st == mmlp_pkg::ST_OK) begin
            case (fld)
                mmlp_pkg::FLD_ADDR:  st = mmlp_pkg::ST_NO_SP_ADDR;
                mmlp_pkg::FLD_PERM:  st = mmlp_pkg::ST_NO_SP_PERM;
                mmlp_pkg::FLD_OFFS:  st = mmlp_pkg::ST_NO_SP_OFFS;
                mmlp_pkg::FLD_DEV:   st = mmlp_pkg::ST_NO_SP_DEV;
                mmlp_pkg::FLD_INODE: st = mmlp_pkg::ST_NO_SP_INODE;
                default:             st = mmlp_pkg::ST_OK;
            endcase
        end
        plen = (fpos < PATH_CAPACITY) ? fpos : PATH_CAPACITY;
        r = '0;
        r.status = st;
        if (st == mmlp_pkg::ST_OK || st >= mmlp_pkg::ST_BAD_END) r.base_addr = acc_start;
        if (st == mmlp_pkg::ST_OK || st >= mmlp_pkg::ST_NO_SP_PERM) r.limit_addr = acc_end;
        if (st == mmlp_pkg::ST_OK || st >= mmlp_pkg::ST_NO_SP_OFFS) begin
            r.access_bits = perm[2:0];
            r.sharing     = perm[3] ? mmlp_pkg::SHR_PRIVATE
                          : (perm[4] ? mmlp_pkg::SHR_SHARED : mmlp_pkg::SHR_NONE);
        end
        if (st == mmlp_pkg::ST_OK || st >= mmlp_pkg::ST_NO_SP_DEV) r.file_offset = acc_offs;
        if (st == mmlp_pkg::ST_OK || st >= mmlp_pkg::ST_NO_SP_INODE) begin
            r.dev_major = acc_dev[7:0];
            r.dev_minor = acc_dev[15:8];
        end
        if (st == mmlp_pkg::ST_OK) begin
            r.inode_num  = acc_inode;
            r.path_start = pbase[11:0];
            r.path_len   = plen[8:0];
        end
        expected_recs = {expected_recs, r};
        clear_line();
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            fails++;
        end
    endtask

    // Compare records first, then take the request byte of this edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_line();
            expected_recs.delete();
        end else begin
            if (i_rec.valid && i_rec.ready) begin
                if (expected_recs.size() == 0) begin
                    $display("%0t: record with status %0d arrived with none expected",
                             $time, i_rec.status);
                    fails++;
                end else begin
                    oldest = expected_recs.pop_front();
                    check_field("base_addr", oldest.base_addr, i_rec.base_addr);
                    check_field("limit_addr", oldest.limit_addr, i_rec.limit_addr);
                    check_field("access_bits", 64'(oldest.access_bits),
                                64'(i_rec.access_bits));
                    check_field("sharing", 64'(oldest.sharing), 64'(i_rec.sharing));
                    check_field("file_offset", oldest.file_offset, i_rec.file_offset);
                    check_field("dev_major", 64'(oldest.dev_major), 64'(i_rec.dev_major));
                    check_field("dev_minor", 64'(oldest.dev_minor), 64'(i_rec.dev_minor));
                    check_field("inode_num", oldest.inode_num, i_rec.inode_num);
                    check_field("path_start", 64'(oldest.path_start),
                                64'(i_rec.path_start));
                    check_field("path_len", 64'(oldest.path_len), 64'(i_rec.path_len));
                    check_field("status", 64'(oldest.status), 64'(i_rec.status));
                end
            end
            if (i_req.valid && i_req.ready) begin
                if (fail == mmlp_pkg::ST_OK) parse_char(i_req.char_in);
                lpos = bump(lpos);
                if (i_req.line_end) close_line();
            end
        end
        o_mismatches  <= fails;
        o_outstanding <= expected_recs.size();
    end

endmodule

// File: sim/tb_memory_map_line_parser_unit.sv
// Testbench top of the memory map line parser: line stimulus, handshake pacing and verdict.
module tb_memory_map_line_parser_unit;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_BYTES   = 420;
    localparam int PHASE_BYTES    = 110;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    int src_idle     = 0;
    int snk_stall    = 0;
    int quiet_cycles = 0;
    int bytes_sent   = 0;
    int mismatches;
    int outstanding;

    logic [7:0] line_buf[$];

    mmlp_req_if req_ch();
    mmlp_rec_if rec_ch();

    memory_map_line_parser_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rec   (rec_ch)
    );

    mmlp_record_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_ch),
        .i_rec         (rec_ch),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always #1 i_clk = ~i_clk;

    // Stall the record channel at the rate of the current phase
    always @(posedge i_clk) begin
        rec_ch.ready <= ($urandom_range(99) >= snk_stall);
    end

    // Abort when neither channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rec_ch.valid && rec_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Append one byte to the line being built
    task automatic add_byte(input logic [7:0] b);
        line_buf = {line_buf, b};
    endtask

    function automatic logic [7:0] hex_glyph(input int nib, input logic upper);
        if (nib < 10) return mmlp_pkg::CH_0 + 8'(nib);
        return (upper ? mmlp_pkg::CH_UA : mmlp_pkg::CH_LA) + 8'(nib - 10);
    endfunction

    task automatic put_text(input string s);
        foreach (s[i]) add_byte(s[i]);
    endtask

    task automatic put_hex(input int n);
        repeat (n) add_byte(hex_glyph($urandom_range(15), 1'($urandom_range(1))));
    endtask

    task automatic put_decimal(input int n);
        repeat (n) add_byte(mmlp_pkg::CH_0 + 8'($urandom_range(9)));
    endtask

    // Offer one request, idling first as the phase asks
    task automatic send_char(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < src_idle) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.char_in  <= c;
        req_ch.line_end <= last;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    task automatic ship_line();
        if (line_buf.size() == 0) add_byte(8'($urandom_range(255)));
        foreach (line_buf[i]) send_char(line_buf[i], i == line_buf.size() - 1);
        bytes_sent += line_buf.size();
        line_buf.delete();
    endtask

    task automatic ship_text(input string s);
        put_text(s);
        ship_line();
    endtask

    function automatic int hex_len();
        int r;
        r = $urandom_range(99);
        if (r < 4) return 0;
        if (r < 8) return 17;
        if (r < 15) return 16;
        return $urandom_range(1, 12);
    endfunction

    // Build a map line with random content, now and then malformed
    task automatic build_map_line();
        int r;
        int n;
        put_hex(hex_len());
        add_byte(mmlp_pkg::CH_HYPHEN);
        put_hex(hex_len());
        add_byte(mmlp_pkg::CH_SPACE);
        // permissions, now and then short or long
        n = ($urandom_range(9) == 0) ? $urandom_range(0, 6) : 4;
        for (int i = 0; i < n; i++) begin
            case (i)
                0: add_byte($urandom_range(1) ? mmlp_pkg::CH_R : mmlp_pkg::CH_HYPHEN);
                1: add_byte($urandom_range(1) ? mmlp_pkg::CH_W : mmlp_pkg::CH_HYPHEN);
                2: add_byte($urandom_range(1) ? mmlp_pkg::CH_X : mmlp_pkg::CH_HYPHEN);
                3: begin
                    case ($urandom_range(2))
                        0: add_byte(mmlp_pkg::CH_P);
                        1: add_byte(mmlp_pkg::CH_S);
                        default: add_byte(mmlp_pkg::CH_HYPHEN);
                    endcase
                end
                default: add_byte($urandom_range(1) ? mmlp_pkg::CH_S : mmlp_pkg::CH_R);
            endcase
        end
        add_byte(mmlp_pkg::CH_SPACE);
        put_hex(hex_len());
        add_byte(mmlp_pkg::CH_SPACE);
        // device, now and then malformed
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(0, 7)) begin
                if ($urandom_range(3) == 0) add_byte($urandom_range(1) ? 8'h3A : 8'h67);
                else put_hex(1);
            end
        end else begin
            put_hex(2);
            add_byte(8'h3A);
            put_hex(2);
        end
        add_byte(mmlp_pkg::CH_SPACE);
        // inode, with values around the 64-bit limit
        r = $urandom_range(99);
        if (r < 5) begin
        end else if (r < 10) begin
            put_text("18446744073709551615");
        end else if (r < 15) begin
            put_text("18446744073709551616");
        end else if (r < 25) begin
            add_byte(mmlp_pkg::CH_0 + 8'd1);
            put_decimal(19);
        end else begin
            put_decimal($urandom_range(1, 19));
        end
        add_byte(mmlp_pkg::CH_SPACE);
        // pathname
        repeat ($urandom_range(0, 3)) add_byte(mmlp_pkg::CH_SPACE);
        n = ($urandom_range(99) < 3) ? $urandom_range(257, 300) : $urandom_range(0, 30);
        repeat (n) begin
            if ($urandom_range(15) == 0) add_byte(mmlp_pkg::CH_SPACE);
            else add_byte(8'($urandom_range(33, 126)));
        end
    endtask

    // Break a line: cut it short, overwrite a byte or slip in a separator
    task automatic mangle_line();
        int idx;
        int n;
        idx = $urandom_range(line_buf.size() - 1);
        case ($urandom_range(3))
            0: begin
                n = $urandom_range(1, line_buf.size());
                while (line_buf.size() > n) void'(line_buf.pop_back());
            end
            1: line_buf[idx] = 8'($urandom_range(255));
            2: line_buf[idx] = mmlp_pkg::CH_SPACE;
            default: line_buf.insert(idx, $urandom_range(1) ? mmlp_pkg::CH_SPACE
                                                            : mmlp_pkg::CH_HYPHEN);
        endcase
    endtask

    task automatic build_random_line();
        int r;
        r = $urandom_range(99);
        if (r < 8) begin
            repeat ($urandom_range(1, 20)) add_byte(8'($urandom_range(255)));
        end else begin
            build_map_line();
            if (r >= 70) mangle_line();
        end
    endtask

    task automatic set_phase(input int p);
        case (p)
            0: begin src_idle = 0;  snk_stall <= 0;  end
            1: begin src_idle = 67; snk_stall <= 0;  end
            2: begin src_idle = 0;  snk_stall <= 67; end
            default: begin src_idle = 19; snk_stall <= 19; end
        endcase
    endtask

    initial begin
        req_ch.valid    = 1'b0;
        req_ch.char_in  = 8'h00;
        req_ch.line_end = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed lines: extremes, every status and the special cases
        ship_text("00400000-0040b000 r-xp 00000000 08:02 173521 /usr/bin/daemon");
        ship_text({"ffffffffffffffff-FFFFFFFFFFFFFFFF rwxs fFfFfFfFfFfFfFfF ff:FF ",
                   "18446744073709551615 [stack]"});
        ship_text("0-0 ---- 0 00:00 0 ");
        ship_text("0-0 ---p 0 00:00 0      ");
        ship_text("0-0 ---- 0 00:00 0    /lib x");
        ship_text("00400000");
        ship_text("00400000 ");
        ship_text("-1000 rwxp");
        ship_text("1g-2 ");
        ship_text("10000000000000000-1 ");
        ship_text("1- ");
        ship_text("1-2z r");
        ship_text("1-2 rw");
        ship_text("1-2 r 10");
        ship_text("1-2 rwxps 5");
        ship_text("1-2 rw-s +5 x");
        ship_text("1-2 rw-s  0");
        ship_text("1-2 rwxp 0 08:0");
        ship_text("1-2 rwxp 0 8 5");
        ship_text("1-2 rwxp 0 zz:1k 5 /x");
        ship_text("1-2 rwxp 0 0a/0bx: 7 /x");
        ship_text("1-2 r-xp 0 08:02 18446744073709551616 x");
        ship_text("1-2 r-xp 0 08:02 12a /x");
        ship_text("zz-1 rwxp 0 0 0 path");
        add_byte(8'h00);
        add_byte(8'hFF);
        repeat (6) add_byte(8'($urandom_range(128, 255)));
        ship_line();
        // pathname beyond the buffer
        put_text("1-2 rwxp 0 00:00 1 ");
        repeat (300) add_byte(8'($urandom_range(33, 126)));
        ship_line();

        // Random lines through the pacing phases
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            set_phase((bytes_sent / PHASE_BYTES) % 4);
            build_random_line();
            ship_line();
        end
        req_ch.valid <= 1'b0;

        // Drain the records still owed, then allow for the output latency
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
